>>> rtl/rvt_pkg.sv
package rvt_pkg;

  // Walk limits
  localparam int MAX_STEPS   = 64;
  localparam int DIR_EPSILON = 1;
  localparam int CELL_LIMIT  = 1 << 20;
  localparam int STEP_W      = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

  // Datapath widths
  localparam int CW     = 22;  // cell index
  localparam int TW     = 50;  // slab ray parameter
  localparam int IW     = 48;  // cell crossing increment
  localparam int DIV_W  = 64;  // divider dividend / quotient
  localparam int DCNT_W = $clog2(DIV_W);

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_CELL_SIZE     = 3'd0,
    REG_INV_CELL_SIZE = 3'd1,
    REG_BMIN_X        = 3'd2,
    REG_BMIN_Y        = 3'd3,
    REG_BMIN_Z        = 3'd4,
    REG_BMAX_X        = 3'd5,
    REG_BMAX_Y        = 3'd6,
    REG_BMAX_Z        = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [30:0]      cell_size;
    logic [30:0]      inv_cell_size;
    logic [2:0][31:0] bmin;
    logic [2:0][31:0] bmax;
  } cfg_t;

  // One set-up ray handed from the front end to the walker
  typedef struct packed {
    logic [2:0][CW-1:0]  cidx;
    logic [2:0][63:0]    tnext;
    logic [2:0][IW-1:0]  tinc;
    logic [2:0]          par;
    logic [2:0]          neg;
    logic [30:0]         t1;
  } walk_t;

  typedef enum logic [3:0] {
    F_IDLE,
    F_CHECK,
    F_SLAB,
    F_SLAB_WAIT,
    F_CLIP,
    F_MUL_D,
    F_START,
    F_MUL_INV,
    F_CELL,
    F_MUL_PLANE,
    F_DIFF,
    F_DIV_NEXT,
    F_WAIT_NEXT,
    F_DIV_INC,
    F_WAIT_INC,
    F_PUSH
  } front_state_e;

endpackage

>>> rtl/rvt_div.sv
module rvt_div
  import rvt_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    go_i,
  input  logic signed [DIV_W-1:0] num_i,
  input  logic signed [32:0]      den_i,
  output logic                    done_o,
  output logic signed [DIV_W-1:0] quot_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]  num_q, num_d;
  logic [31:0]       rem_q, rem_d;
  logic [31:0]       den_q, den_d;
  logic              neg_q, neg_d;
  logic [32:0]       rem_sh;
  logic [32:0]       rem_sub;
  logic              ge;

  // One restoring step: shift in a dividend bit, subtract if it fits
  assign rem_sh  = {rem_q, num_q[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign ge      = rem_sh >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    if (go_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      num_d  = num_i[DIV_W-1] ? DIV_W'(-num_i) : num_i;
      den_d  = den_i[32] ? 32'(-den_i) : den_i[31:0];
      neg_d  = num_i[DIV_W-1] ^ den_i[32];
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[31:0] : rem_sh[31:0];
      num_d = {num_q[DIV_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DCNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  // Apply the quotient sign (truncation toward zero)
  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed(num_q) : $signed(num_q);

endmodule

>>> rtl/rvt_front.sv
module rvt_front
  import rvt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] origin_x_i,
  input  logic [31:0] origin_y_i,
  input  logic [31:0] origin_z_i,
  input  logic [31:0] dir_x_i,
  input  logic [31:0] dir_y_i,
  input  logic [31:0] dir_z_i,
  input  logic [30:0] max_distance_i,
  input  cfg_t        cfg_i,
  input  logic        full_i,
  output logic        push_o,
  output walk_t       entry_o
);

  front_state_e state_q, state_d;

  logic signed [31:0]    o_q [3];
  logic signed [31:0]    o_d [3];
  logic signed [31:0]    d_q [3];
  logic signed [31:0]    d_d [3];
  logic [2:0]            par_q, par_d;
  logic signed [TW-1:0]  t0_q, t0_d, t1_q, t1_d, qlo_q, qlo_d;
  logic [1:0]            axis_q, axis_d;
  logic                  side_q, side_d;
  logic signed [63:0]    prod_q, prod_d;
  logic signed [31:0]    start_q, start_d;
  logic signed [IW-1:0]  diff_q, diff_d;
  logic [2:0][CW-1:0]    cell_q, cell_d;
  logic [2:0][63:0]      tnext_q, tnext_d;
  logic [2:0][IW-1:0]    tinc_q, tinc_d;

  logic                  div_go, div_done;
  logic signed [63:0]    div_num, div_quot;
  logic signed [32:0]    div_den;
  logic signed [31:0]    mul_a, mul_b;

  logic                  last_axis;
  logic                  miss_chk;
  logic signed [31:0]    cur_o, cur_d;
  logic [31:0]           abs_d;
  logic signed [32:0]    slab_diff;
  logic signed [TW-1:0]  q_s, tn, tf;
  logic signed [48:0]    start_sum;
  logic signed [31:0]    cell_raw;
  logic signed [22:0]    cell_plus;
  logic signed [63:0]    plane_diff;

  function automatic logic is_par(logic signed [31:0] d);
    logic signed [32:0] a;
    a = d[31] ? -$signed({d[31], d}) : $signed({d[31], d});
    return (d == 32'sd0) || (a < $signed(33'(DIR_EPSILON)));
  endfunction

  rvt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (div_go),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign last_axis = (axis_q == 2'd2);
  assign cur_o     = o_q[axis_q];
  assign cur_d     = d_q[axis_q];
  assign abs_d     = cur_d[31] ? 32'(-$signed({cur_d[31], cur_d})) : cur_d;
  assign slab_diff = $signed({side_q ? cfg_i.bmax[axis_q][31] : cfg_i.bmin[axis_q][31],
                              side_q ? cfg_i.bmax[axis_q] : cfg_i.bmin[axis_q]})
                     - $signed({cur_o[31], cur_o});
  assign q_s       = div_quot[TW-1:0];
  assign cell_plus = $signed({cell_q[axis_q][CW-1], cell_q[axis_q]})
                     + $signed({22'b0, ~cur_d[31]});

  // Invalid box or a parallel axis with the origin outside its slab
  always_comb begin
    miss_chk = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if ($signed(cfg_i.bmin[i]) > $signed(cfg_i.bmax[i])) miss_chk = 1'b1;
      if (par_q[i] && ((o_q[i] < $signed(cfg_i.bmin[i])) ||
                       (o_q[i] > $signed(cfg_i.bmax[i])))) miss_chk = 1'b1;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE:      if (start_i) state_d = F_CHECK;
      F_CHECK:     state_d = miss_chk ? F_IDLE : F_SLAB;
      F_SLAB: begin
        if (!par_q[axis_q]) state_d = F_SLAB_WAIT;
        else if (last_axis) state_d = F_CLIP;
      end
      F_SLAB_WAIT: if (div_done) state_d = (side_q && last_axis) ? F_CLIP : F_SLAB;
      F_CLIP:      state_d = (t0_q > t1_q) ? F_IDLE : F_MUL_D;
      F_MUL_D:     state_d = F_START;
      F_START:     state_d = F_MUL_INV;
      F_MUL_INV:   state_d = F_CELL;
      F_CELL:      state_d = F_MUL_PLANE;
      F_MUL_PLANE: state_d = F_DIFF;
      F_DIFF: begin
        if (!par_q[axis_q]) state_d = F_DIV_NEXT;
        else state_d = last_axis ? F_PUSH : F_MUL_D;
      end
      F_DIV_NEXT:  state_d = F_WAIT_NEXT;
      F_WAIT_NEXT: if (div_done) state_d = F_DIV_INC;
      F_DIV_INC:   state_d = F_WAIT_INC;
      F_WAIT_INC:  if (div_done) state_d = last_axis ? F_PUSH : F_MUL_D;
      F_PUSH:      if (!full_i) state_d = F_IDLE;
      default:     state_d = F_IDLE;
    endcase
  end

  // Divider, multiplier and queue controls
  always_comb begin
    div_go  = 1'b0;
    div_num = '0;
    div_den = '0;
    mul_a   = '0;
    mul_b   = '0;
    push_o  = 1'b0;
    case (state_q)
      F_SLAB: begin
        div_go  = !par_q[axis_q];
        div_num = {{15{slab_diff[32]}}, slab_diff, 16'b0};
        div_den = {cur_d[31], cur_d};
      end
      F_DIV_NEXT: begin
        div_go  = 1'b1;
        div_num = {diff_q, 16'b0};
        div_den = {cur_d[31], cur_d};
      end
      F_DIV_INC: begin
        div_go  = 1'b1;
        div_num = {17'b0, cfg_i.cell_size, 16'b0};
        div_den = {1'b0, abs_d};
      end
      F_MUL_D: begin
        mul_a = cur_d;
        mul_b = t0_q[31:0];
      end
      F_MUL_INV: begin
        mul_a = start_q;
        mul_b = {1'b0, cfg_i.inv_cell_size};
      end
      F_MUL_PLANE: begin
        mul_a = {{9{cell_plus[22]}}, cell_plus};
        mul_b = {1'b0, cfg_i.cell_size};
      end
      F_PUSH:  push_o = !full_i;
      default: ;
    endcase
  end

  assign prod_d     = mul_a * mul_b;
  assign start_sum  = $signed({{17{cur_o[31]}}, cur_o}) + $signed({prod_q[63], prod_q[63:16]});
  assign cell_raw   = prod_q[63:32];
  assign plane_diff = prod_q - $signed({{32{start_q[31]}}, start_q});

  // Datapath updates
  always_comb begin
    o_d     = o_q;
    d_d     = d_q;
    par_d   = par_q;
    t0_d    = t0_q;
    t1_d    = t1_q;
    qlo_d   = qlo_q;
    axis_d  = axis_q;
    side_d  = side_q;
    start_d = start_q;
    diff_d  = diff_q;
    cell_d  = cell_q;
    tnext_d = tnext_q;
    tinc_d  = tinc_q;
    tn      = (qlo_q < q_s) ? qlo_q : q_s;
    tf      = (qlo_q < q_s) ? q_s : qlo_q;
    case (state_q)
      F_IDLE: begin
        if (start_i) begin
          o_d[0] = origin_x_i;
          o_d[1] = origin_y_i;
          o_d[2] = origin_z_i;
          d_d[0] = dir_x_i;
          d_d[1] = dir_y_i;
          d_d[2] = dir_z_i;
          par_d  = {is_par(dir_z_i), is_par(dir_y_i), is_par(dir_x_i)};
          t0_d   = '0;
          t1_d   = {19'b0, max_distance_i};
          axis_d = 2'd0;
          side_d = 1'b0;
        end
      end
      F_SLAB: begin
        if (par_q[axis_q]) axis_d = axis_q + 2'd1;
      end
      F_SLAB_WAIT: begin
        if (div_done) begin
          if (!side_q) begin
            qlo_d  = q_s;
            side_d = 1'b1;
          end else begin
            // Narrow the clip interval with this slab
            if (tn > t0_q) t0_d = tn;
            if (tf < t1_q) t1_d = tf;
            side_d = 1'b0;
            axis_d = axis_q + 2'd1;
          end
        end
      end
      F_CLIP:  axis_d = 2'd0;
      F_START: begin
        if (start_sum > 49'sh0_7FFF_FFFF) start_d = 32'sh7FFF_FFFF;
        else if (start_sum < -49'sh0_8000_0000) start_d = 32'sh8000_0000;
        else start_d = start_sum[31:0];
      end
      F_CELL: begin
        if (cell_raw > 32'(CELL_LIMIT)) cell_d[axis_q] = CW'(CELL_LIMIT);
        else if (cell_raw < -32'(CELL_LIMIT)) cell_d[axis_q] = CW'(-CELL_LIMIT);
        else cell_d[axis_q] = cell_raw[CW-1:0];
      end
      F_DIFF: begin
        // Clamp far plane offsets
        if (plane_diff > (64'sd1 <<< 46)) diff_d = IW'(64'sd1 <<< 46);
        else if (plane_diff < -(64'sd1 <<< 46)) diff_d = IW'(-(64'sd1 <<< 46));
        else diff_d = plane_diff[IW-1:0];
        if (par_q[axis_q]) begin
          tnext_d[axis_q] = 64'h7FFF_FFFF_FFFF_FFFF;
          tinc_d[axis_q]  = '0;
          axis_d          = axis_q + 2'd1;
        end
      end
      F_WAIT_NEXT: begin
        if (div_done) tnext_d[axis_q] = $signed({{14{t0_q[TW-1]}}, t0_q}) + div_quot;
      end
      F_WAIT_INC: begin
        if (div_done) begin
          tinc_d[axis_q] = div_quot[IW-1:0];
          axis_d         = axis_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    o_q     <= o_d;
    d_q     <= d_d;
    par_q   <= par_d;
    t0_q    <= t0_d;
    t1_q    <= t1_d;
    qlo_q   <= qlo_d;
    axis_q  <= axis_d;
    side_q  <= side_d;
    prod_q  <= prod_d;
    start_q <= start_d;
    diff_q  <= diff_d;
    cell_q  <= cell_d;
    tnext_q <= tnext_d;
    tinc_q  <= tinc_d;
  end

  assign busy_o = (state_q != F_IDLE);

  always_comb begin
    entry_o.cidx  = cell_q;
    entry_o.tnext = tnext_q;
    entry_o.tinc  = tinc_q;
    entry_o.par   = par_q;
    entry_o.neg   = {d_q[2][31], d_q[1][31], d_q[0][31]};
    entry_o.t1    = t1_q[30:0];
  end

endmodule

>>> rtl/rvt_fifo.sv
module rvt_fifo
  import rvt_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  walk_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output walk_t data_o
);

  walk_t      mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

>>> rtl/rvt_walk.sv
module rvt_walk
  import rvt_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  walk_t         head_i,
  output logic          pop_o,
  output logic          cell_valid_o,
  output logic [CW-1:0] cell_x_o,
  output logic [CW-1:0] cell_y_o,
  output logic [CW-1:0] cell_z_o,
  output logic          last_o
);

  logic               active_q, active_d;
  logic [STEP_W-1:0]  n_q, n_d;
  walk_t              cur_q, cur_d;
  logic               valid_q, valid_d;
  logic [2:0][CW-1:0] outc_q, outc_d;
  logic               last_q, last_d;
  logic [1:0]         sel;
  logic signed [63:0] tsel;
  logic               fin;
  logic signed [22:0] cstep;

  // Pick the nearest plane crossing, lower axis on ties
  always_comb begin
    sel = 2'd0;
    if ($signed(cur_q.tnext[1]) < $signed(cur_q.tnext[0])) sel = 2'd1;
    if ($signed(cur_q.tnext[2]) < $signed(cur_q.tnext[sel])) sel = 2'd2;
    tsel  = $signed(cur_q.tnext[sel]);
    fin   = (tsel > $signed({33'b0, cur_q.t1})) || (n_q == STEP_W'(MAX_STEPS - 1));
    cstep = $signed({cur_q.cidx[sel][CW-1], cur_q.cidx[sel]})
            + (cur_q.neg[sel] ? -23'sd1 : 23'sd1);
  end

  always_comb begin
    pop_o    = !active_q && !empty_i;
    active_d = active_q;
    n_d      = n_q;
    cur_d    = cur_q;
    valid_d  = 1'b0;
    outc_d   = outc_q;
    last_d   = last_q;
    if (pop_o) begin
      cur_d    = head_i;
      active_d = 1'b1;
      n_d      = '0;
    end else if (active_q) begin
      // Emit the current cell, then step across the chosen plane unless it is the last
      valid_d = 1'b1;
      outc_d  = cur_q.cidx;
      last_d  = fin;
      if (fin) begin
        active_d = 1'b0;
      end else begin
        n_d = n_q + 1'b1;
        if (cstep > 23'(CELL_LIMIT)) cur_d.cidx[sel] = CW'(CELL_LIMIT);
        else if (cstep < -23'(CELL_LIMIT)) cur_d.cidx[sel] = CW'(-CELL_LIMIT);
        else cur_d.cidx[sel] = cstep[CW-1:0];
        cur_d.tnext[sel] = tsel + $signed({16'b0, cur_q.tinc[sel]});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      active_q <= active_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    cur_q  <= cur_d;
    outc_q <= outc_d;
    last_q <= last_d;
  end

  assign cell_valid_o = valid_q;
  assign cell_x_o     = outc_q[0];
  assign cell_y_o     = outc_q[1];
  assign cell_z_o     = outc_q[2];
  assign last_o       = last_q;

endmodule

>>> rtl/ray_voxel_traversal_core.sv
// Ray setup runs on one shared serial divider (issue, one restoring step per bit, done).
// Setup runs four divisions per non-parallel axis and none for a parallel axis.
// The queue push waits while the queue is full; the walker pops an entry only when idle.
// The walker emits one cell per cycle, up to 64 cells, while the next ray is set up.
// Results come out as one-cycle strobes and cannot be stalled by the receiver.
// Reset (rst_ni low, asynchronous) clears all control state and loads register defaults.
module ray_voxel_traversal_core
  import rvt_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  logic [31:0]   origin_x_i,
  input  logic [31:0]   origin_y_i,
  input  logic [31:0]   origin_z_i,
  input  logic [31:0]   dir_x_i,
  input  logic [31:0]   dir_y_i,
  input  logic [31:0]   dir_z_i,
  input  logic [30:0]   max_distance_i,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i,
  output logic          cell_valid_o,
  output logic [CW-1:0] cell_x_o,
  output logic [CW-1:0] cell_y_o,
  output logic [CW-1:0] cell_z_o,
  output logic          last_o
);

  cfg_t  cfg_q, cfg_d;
  walk_t push_data, head;
  logic  push, full, pop, empty;

  assign cfg_ready_o = 1'b1;

  // Configuration register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_CELL_SIZE:     cfg_d.cell_size     = cfg_data_i[30:0];
        REG_INV_CELL_SIZE: cfg_d.inv_cell_size = cfg_data_i[30:0];
        REG_BMIN_X:        cfg_d.bmin[0]       = cfg_data_i;
        REG_BMIN_Y:        cfg_d.bmin[1]       = cfg_data_i;
        REG_BMIN_Z:        cfg_d.bmin[2]       = cfg_data_i;
        REG_BMAX_X:        cfg_d.bmax[0]       = cfg_data_i;
        REG_BMAX_Y:        cfg_d.bmax[1]       = cfg_data_i;
        REG_BMAX_Z:        cfg_d.bmax[2]       = cfg_data_i;
        default:           cfg_d               = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cell_size     <= 31'd65536;
      cfg_q.inv_cell_size <= 31'd65536;
      cfg_q.bmin          <= {3{32'h7FFF_FFFF}};
      cfg_q.bmax          <= {3{32'h8000_0000}};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rvt_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_o         (busy),
    .origin_x_i     (origin_x_i),
    .origin_y_i     (origin_y_i),
    .origin_z_i     (origin_z_i),
    .dir_x_i        (dir_x_i),
    .dir_y_i        (dir_y_i),
    .dir_z_i        (dir_z_i),
    .max_distance_i (max_distance_i),
    .cfg_i          (cfg_q),
    .full_i         (full),
    .push_o         (push),
    .entry_o        (push_data)
  );

  rvt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (head)
  );

  rvt_walk u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .head_i       (head),
    .pop_o        (pop),
    .cell_valid_o (cell_valid_o),
    .cell_x_o     (cell_x_o),
    .cell_y_o     (cell_y_o),
    .cell_z_o     (cell_z_o),
    .last_o       (last_o)
  );

endmodule
